/* hw/rtl/wprs_pkg.sv */
// ----------------------------------------------------------------------------
// wprs_pkg
// Types, codes and the calendar table of the weighted priority ready scheduler.
// ----------------------------------------------------------------------------
package wprs_pkg;

    localparam int TASK_W  = 6;
    localparam int LVL_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int CAL_LEN = 10;

    localparam logic [LVL_W-1:0]  TOP_LEVEL  = 2'd3;
    localparam logic [2:0]        JOIN_BOOST = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(CAL_LEN - 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [LVL_W-1:0] LVL_LOW    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_ULTRA  = 2'd3;

    typedef struct packed {
        logic              command;
        logic [TASK_W-1:0] task_id;
        logic [1:0]        base_priority;
        logic              join_waited;
        logic              mutex_held;
    } req_t;

    typedef struct packed {
        logic              task_valid;
        logic [TASK_W-1:0] task_out;
        logic              queue_full;
        logic [LVL_W-1:0]  level_used;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_READ
    } state_t;

    // high, ultra, medium, ultra, high, medium, ultra, high, ultra, low
    function automatic logic [LVL_W-1:0] cal_level(input logic [SLOT_W-1:0] slot);
        logic [LVL_W-1:0] lv;
        unique case (slot)
            4'd0:    lv = LVL_HIGH;
            4'd1:    lv = LVL_ULTRA;
            4'd2:    lv = LVL_MEDIUM;
            4'd3:    lv = LVL_ULTRA;
            4'd4:    lv = LVL_HIGH;
            4'd5:    lv = LVL_MEDIUM;
            4'd6:    lv = LVL_ULTRA;
            4'd7:    lv = LVL_HIGH;
            4'd8:    lv = LVL_ULTRA;
            4'd9:    lv = LVL_LOW;
            default: lv = LVL_LOW;
        endcase
        return lv;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        return (slot >= SLOT_LAST) ? '0 : slot + SLOT_W'(1);
    endfunction

endpackage

/* hw/rtl/wprs_qmem.sv */
// ----------------------------------------------------------------------------
// wprs_qmem
// Task id storage of all four queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wprs_qmem #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/weighted_priority_ready_scheduler_core.sv */
// ----------------------------------------------------------------------------
// weighted_priority_ready_scheduler_core
// Four-level ready-task queue with a ten-slot weighted calendar for pops.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one request at a time: a push
//   of a task id with its priority hints, or a pop. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one response per request.
//   A push answers from the push state, which resolves the level, checks the
//   fill count and writes the queue memory.
//   A pop checks one calendar slot per cycle (up to ten slots) and, on a hit,
//   answers after the registered memory read; a pop that finds every queue
//   empty answers after its ten slot checks.
//   req_ready is high only while the sequencer is idle, so a new request is
//   taken only after the previous one has answered.
//   All four queues share one memory with one write and one read port.
//   Reset clears heads, counts, calendar slot and the response valid flag;
//   queue memory needs no clearing since an entry is only read after it is
//   written.
//   If rsp_ready is low the response register holds; a finished request can
//   still be accepted, and the next response waits in the sequencer until the
//   register frees up, without changing queue state.
// ----------------------------------------------------------------------------
module weighted_priority_ready_scheduler_core #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  wprs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output wprs_pkg::rsp_t rsp
);

    import wprs_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int EXT_W  = (TASK_ID_BITS > TASK_W) ? TASK_ID_BITS : TASK_W;

    state_t state_reg, state_next;

    req_t              req_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] scan_slot_reg;
    logic [SLOT_W-1:0] step_reg;
    logic [LVL_W-1:0]  hit_lvl_reg;
    logic [IDX_W-1:0]  head_reg  [4];
    logic [CNT_W-1:0]  count_reg [4];
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic [2:0]        prio_sum;
    logic [LVL_W-1:0]  push_lvl;
    logic [LVL_W-1:0]  scan_lvl;
    logic [LVL_W-1:0]  sel_lvl;
    logic [IDX_W-1:0]  sel_head;
    logic [CNT_W-1:0]  sel_cnt;
    logic              sel_full;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_idx;
    logic [IDX_W-1:0]  head_inc;
    logic              out_free;
    logic              scan_hit;
    logic              scan_last;

    logic              commit;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [TASK_ID_BITS-1:0] mem_wdata;
    logic [TASK_ID_BITS-1:0] mem_rdata;
    logic [EXT_W-1:0]  rd_ext;
    rsp_t              result;

    // ---- datapath ----
    assign prio_sum = {1'b0, req_reg.base_priority}
                    + (req_reg.join_waited ? JOIN_BOOST : 3'd0)
                    + {2'b00, req_reg.mutex_held};
    assign push_lvl = (prio_sum > {1'b0, TOP_LEVEL}) ? TOP_LEVEL : prio_sum[LVL_W-1:0];
    assign scan_lvl = cal_level(scan_slot_reg);

    always_comb
    begin
        unique case (state_reg)
            S_PUSH:  sel_lvl = push_lvl;
            S_READ:  sel_lvl = hit_lvl_reg;
            default: sel_lvl = scan_lvl;
        endcase
    end

    assign sel_head = head_reg[sel_lvl];
    assign sel_cnt  = count_reg[sel_lvl];
    assign sel_full = (sel_cnt >= CNT_W'(QUEUE_DEPTH));

    assign tail_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                    : IDX_W'(tail_sum);
    assign head_inc = (sel_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + IDX_W'(1);

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign scan_hit  = (sel_cnt != '0);
    assign scan_last = (step_reg == SLOT_LAST);

    assign mem_waddr = {push_lvl, tail_idx};
    assign mem_raddr = {scan_lvl, sel_head};
    assign mem_wdata = TASK_ID_BITS'(req_reg.task_id);
    assign rd_ext    = EXT_W'(mem_rdata);

    wprs_qmem #(
        .ADDR_W (ADDR_W),
        .DATA_W (TASK_ID_BITS)
    ) u_qmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.command == CMD_POP) ? S_SCAN : S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                priority if (scan_hit)
                begin
                    state_next = S_READ;
                end
                else if (scan_last && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        result    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_PUSH:
            begin
                commit            = out_free;
                mem_we            = out_free && !sel_full;
                result.queue_full = sel_full;
                result.level_used = push_lvl;
            end
            S_SCAN:
            begin
                mem_re = scan_hit;
                commit = !scan_hit && scan_last && out_free;
            end
            S_READ:
            begin
                commit            = out_free;
                result.task_valid = 1'b1;
                result.task_out   = rd_ext[TASK_W-1:0];
                result.level_used = hit_lvl_reg;
            end
            default: req_ready = 1'b0;
        endcase
    end

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            scan_slot_reg <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_IDLE && req_valid)
            begin
                scan_slot_reg <= slot_reg;
                step_reg      <= '0;
            end
            else if (state_reg == S_SCAN && !scan_hit && !scan_last)
            begin
                scan_slot_reg <= slot_inc(scan_slot_reg);
                step_reg      <= step_reg + SLOT_W'(1);
            end

            if (mem_we)
            begin
                count_reg[push_lvl] <= sel_cnt + CNT_W'(1);
            end

            // pop retires: heads and calendar slot move only here; the popped count drops here too
            if (state_reg == S_READ && commit)
            begin
                head_reg[hit_lvl_reg]  <= head_inc;
                count_reg[hit_lvl_reg] <= sel_cnt - CNT_W'(1);
                slot_reg               <= slot_inc(scan_slot_reg);
            end

            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        if (state_reg == S_SCAN && scan_hit)
        begin
            hit_lvl_reg <= scan_lvl;
        end
        if (commit)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
